// File: rtl/pcq_pkg.sv
// ----------------------------------------------------------------------------
// pcq_pkg
// Shared types, constants and helper functions of the pitch CV quantizer.
// ----------------------------------------------------------------------------
package pcq_pkg;

  // fixed field and state widths
  localparam int unsigned SampleW  = 8;
  localparam int unsigned SumW     = 12;
  localparam int unsigned CountW   = 4;
  localparam int unsigned NoteW    = 7;
  localparam int unsigned MaskW    = 12;
  localparam int unsigned GainW    = 16;
  localparam int unsigned DacW     = 10;
  localparam int unsigned SpiW     = 16;
  localparam int unsigned ProdW    = SumW + GainW;
  localparam int unsigned PcW      = 4;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgScaleMask = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGain      = 2'd1;
  localparam int unsigned CfgDataW = 16;

  // reset values of the configuration registers
  localparam logic [MaskW-1:0] MaskReset = 12'hFFF;
  localparam logic [GainW-1:0] GainReset = 16'd3044;

  // converter and serial frame constants
  localparam logic [DacW-1:0] DacFull  = 10'd1023;
  localparam logic [SpiW-1:0] SpiCmd   = 16'h7000;
  localparam logic [PcW-1:0]  PcLast   = 4'd11;
  // reciprocal of 15 in 23 fractional bits, exact for 15-bit dividends
  localparam int unsigned DivShift = 23;
  localparam int unsigned MagicW   = 20;
  localparam logic [MagicW-1:0] DivMagic = 20'd559241;
  localparam int unsigned DivIn   = 15;
  localparam int unsigned DivProdW = DivIn + MagicW;

  typedef struct packed {
    logic               channel;
    logic [SampleW-1:0] sample;
  } pcq_in_t;

  typedef struct packed {
    logic             out_channel;
    logic [NoteW-1:0] note_index;
    logic [DacW-1:0]  dac_code;
    logic [SpiW-1:0]  spi_word;
  } pcq_out_t;

  // one completed read, handed from the front to the back
  typedef struct packed {
    logic             channel;
    logic [NoteW-1:0] note_idx;
  } pcq_job_t;

  // note index modulo 12, by threshold compares
  function automatic logic [PcW-1:0] pcq_mod12(logic [NoteW-1:0] idx);
    logic [NoteW-1:0] r;
    r = idx;
    for (int k = 1; k <= 10; k++) begin
      if (idx >= NoteW'(12 * k)) begin
        r = idx - NoteW'(12 * k);
      end
    end
    return r[PcW-1:0];
  endfunction

  // min(1023, floor(idx * 1023 / 60)), as (idx*1023 >> 2) / 15 by reciprocal
  function automatic logic [DacW-1:0] pcq_dac_code(logic [NoteW-1:0] idx);
    logic [NoteW+9:0]    x;
    logic [DivIn-1:0]    d;
    logic [DivProdW-1:0] p;
    logic [DivProdW-DivShift-1:0] q;
    x = {idx, 10'b0} - {10'b0, idx};
    d = x[NoteW+9:2];
    p = DivProdW'(d) * DivProdW'(DivMagic);
    q = p[DivProdW-1:DivShift];
    if (q > (DivProdW-DivShift)'(DacFull)) begin
      return DacFull;
    end
    return q[DacW-1:0];
  endfunction

endpackage

// File: rtl/pcq_front.sv
// ----------------------------------------------------------------------------
// pcq_front
// Sums samples of a read and, on the last one, scales and clamps the sum to
// a note index that is pushed into the job queue.
// ----------------------------------------------------------------------------
module pcq_front #(
  parameter int unsigned SAMPLES_PER_READ = 10,
  parameter int unsigned NOTE_COUNT       = 72
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  pcq_pkg::pcq_in_t               item_i,
  input  logic [pcq_pkg::GainW-1:0]      gain_i,
  output logic                           job_push_o,
  output pcq_pkg::pcq_job_t              job_o,
  input  logic                           job_full_i
);
  import pcq_pkg::*;

  logic [SumW-1:0]   sum_q, sum_d, sum_nxt;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_nxt;
  logic [ProdW-1:0]  prod;
  logic [SumW-1:0]   idx_raw;
  logic              accept, last;

  // accumulate and detect the end of a read
  assign accept  = push_i & ~job_full_i;
  assign full_o  = job_full_i;
  assign sum_nxt = sum_q + SumW'(item_i.sample);
  assign cnt_nxt = cnt_q + CountW'(1);
  assign last    = (cnt_nxt == CountW'(SAMPLES_PER_READ));

  // scale by the gain and clamp to the note range
  assign prod    = ProdW'(sum_nxt) * ProdW'(gain_i);
  assign idx_raw = prod[ProdW-1:GainW];

  always_comb begin
    job_o.channel = item_i.channel;
    if (idx_raw > SumW'(NOTE_COUNT - 1)) begin
      job_o.note_idx = NoteW'(NOTE_COUNT - 1);
    end else begin
      job_o.note_idx = idx_raw[NoteW-1:0];
    end
  end

  assign job_push_o = accept & last;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_nxt;
        cnt_d = cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/pcq_queue.sv
// ----------------------------------------------------------------------------
// pcq_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module pcq_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pcq_pkg::pcq_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output pcq_pkg::pcq_job_t data_o,
  output logic              empty_o
);
  import pcq_pkg::*;

  pcq_job_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/pcq_back.sv
// ----------------------------------------------------------------------------
// pcq_back
// Steps down from the clamped note to the nearest note in the scale, one
// semitone per cycle, and builds the converter code and serial frame.
// ----------------------------------------------------------------------------
module pcq_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_empty_i,
  input  pcq_pkg::pcq_job_t         job_i,
  output logic                      job_pop_o,
  input  logic [pcq_pkg::MaskW-1:0] scale_mask_i,
  output logic                      empty_o,
  input  logic                      pop_i,
  output pcq_pkg::pcq_out_t         item_o
);
  import pcq_pkg::*;

  localparam logic StIdle   = 1'b0;
  localparam logic StSearch = 1'b1;

  logic             state_q, state_d;
  logic [NoteW-1:0] idx_q, idx_d;
  logic [PcW-1:0]   pc_q, pc_d;
  logic             first_q, first_d;
  logic             ch_q, ch_d;
  logic             out_vld_q, out_vld_d;
  pcq_out_t         out_q;
  logic             hit, slot_free, load_out;
  logic [DacW-1:0]  code;

  assign slot_free = ~out_vld_q | pop_i;
  assign hit       = scale_mask_i[pc_q] | (first_q & (idx_q == '0));
  assign load_out  = (state_q == StSearch) & hit & slot_free;
  assign job_pop_o = (state_q == StIdle) & ~job_empty_i;
  assign code      = pcq_dac_code(idx_q);

  // search sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pc_d    = pc_q;
    first_d = first_q;
    ch_d    = ch_q;
    case (state_q)
      StIdle: begin
        if (!job_empty_i && scale_mask_i != '0) begin
          idx_d   = job_i.note_idx;
          pc_d    = pcq_mod12(job_i.note_idx);
          first_d = 1'b1;
          ch_d    = job_i.channel;
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (hit) begin
          if (slot_free) begin
            state_d = StIdle;
          end
        end else if (idx_q == '0) begin
          // nothing enabled below, drop the read
          state_d = StIdle;
        end else begin
          idx_d   = idx_q - NoteW'(1);
          pc_d    = (pc_q == '0) ? PcLast : pc_q - PcW'(1);
          first_d = 1'b0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // output register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (pop_i) begin
      out_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pc_q    <= pc_d;
    first_q <= first_d;
    ch_q    <= ch_d;
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.out_channel <= ch_q;
      out_q.note_index  <= idx_q;
      out_q.dac_code    <= code;
      out_q.spi_word    <= SpiCmd | {4'b0, code, 2'b00};
    end
  end

  assign empty_o = ~out_vld_q;
  assign item_o  = out_q;

endmodule

// File: rtl/pitch_cv_scale_quantizer_unit.sv
// ----------------------------------------------------------------------------
// pitch_cv_scale_quantizer_unit
// Samples are summed per read; the last sample of a read gives at most one
// note result. One sample is taken per cycle while the two-entry job
// queue has room. A completed read is scaled and clamped in the cycle it is
// taken, then the back end picks the job up from its idle state and checks
// one note per step on the way down the scale; with a nonzero mask an enabled
// note lies within 11 semitones below unless index zero comes first. The
// result passes through the job queue, the search registers and the output
// register, where it sits until popped. The downward scale search is what
// sets the time per read; an empty scale mask or no enabled note at or below
// a nonzero index drops the read.
// ----------------------------------------------------------------------------
module pitch_cv_scale_quantizer_unit #(
  parameter int unsigned SAMPLES_PER_READ = 10,
  parameter int unsigned NOTE_COUNT       = 72
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  pcq_pkg::pcq_in_t             in_item_i,
  output logic                         empty,
  input  logic                         pop,
  output pcq_pkg::pcq_out_t            out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pcq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pcq_pkg::CfgDataW-1:0] cfg_data_i
);
  import pcq_pkg::*;

  logic [MaskW-1:0] mask_q;
  logic [GainW-1:0] gain_q;
  logic             job_push, job_full, job_pop, job_empty;
  pcq_job_t         job_in, job_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaskReset;
      gain_q <= GainReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgScaleMask: mask_q <= cfg_data_i[MaskW-1:0];
        CfgGain:      gain_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  pcq_front #(
    .SAMPLES_PER_READ (SAMPLES_PER_READ),
    .NOTE_COUNT       (NOTE_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .item_i     (in_item_i),
    .gain_i     (gain_q),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  pcq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  pcq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_empty_i  (job_empty),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .scale_mask_i (mask_q),
    .empty_o      (empty),
    .pop_i        (pop),
    .item_o       (out_item_o)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pitch CV scale quantizer. A short table of
// whole reads covers the field extremes, an empty scale, a scale with no note
// at or below the index, and a disabled note zero. Randomized phases with
// different scale masks and gains follow. Every accepted sample goes through
// a local note predictor, and each popped note is compared field by field
// with the oldest predicted one. The sample side sends in bursts with gaps,
// the note side stalls on its own patterns, and one long hold on the note
// side backs the block up until it refuses samples.
// ----------------------------------------------------------------------------
module tb_top;
  import pcq_pkg::*;

  localparam int unsigned SamplesPerRead = 10;
  localparam int unsigned NoteCount      = 72;
  localparam int unsigned SemisAtFull    = 60;
  localparam int unsigned SettleCycles   = NoteCount + 24;
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned DirReads       = 7;
  localparam int unsigned RandPhases     = 14;
  localparam int unsigned PhaseSamples   = 70;
  localparam int unsigned HoldPhase      = 5;
  localparam logic [15:0] StallBits      = 16'b1011_0010_1110_0101;

  typedef enum int {RxFree, RxPattern, RxCoin, RxSparse} rx_mode_e;

  // one directed read: register settings, sample level, optional known note
  typedef struct packed {
    logic [CfgDataW-1:0] mask_data;
    logic [CfgDataW-1:0] gain_data;
    logic [SampleW-1:0]  level;
    logic                typed;
    logic                gives;
    pcq_out_t            note;
  } read_row_t;

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                push      = 1'b0;
  logic                full;
  pcq_in_t             in_item   = '0;
  logic                empty;
  logic                pop       = 1'b0;
  pcq_out_t            out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CfgScaleMask;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // predictor state and register shadows
  logic [SumW-1:0]   acc_sum;
  logic [CountW-1:0] acc_count;
  logic [MaskW-1:0]  cur_mask;
  logic [GainW-1:0]  cur_gain;
  pcq_out_t          note_queue[$];

  read_row_t dir_rows [DirReads];
  int        n_errors;
  int        n_samples;
  int        n_notes;
  int        n_writes;
  int        burst_left;
  int        idle_cycles;
  int        rx_cycle;
  int        hold_left;
  bit        hold_req;
  rx_mode_e  rx_mode = RxFree;

  pitch_cv_scale_quantizer_unit #(
    .SAMPLES_PER_READ(SamplesPerRead),
    .NOTE_COUNT      (NoteCount)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // accumulate one sample; on a completed read work out the note, if any
  function automatic bit predict_note(input pcq_in_t it, output pcq_out_t note);
    logic [ProdW-1:0] prod;
    int               idx;
    int               code;
    note = '0;
    acc_sum   = acc_sum + SumW'(it.sample);
    acc_count = acc_count + CountW'(1);
    if (acc_count < CountW'(SamplesPerRead)) return 1'b0;
    prod = ProdW'(acc_sum) * ProdW'(cur_gain);
    idx  = int'(prod >> GainW);
    acc_sum   = '0;
    acc_count = '0;
    if (cur_mask == '0) return 1'b0;
    if (idx > int'(NoteCount) - 1) idx = int'(NoteCount) - 1;
    // step down to the nearest enabled note; a starting index of zero always stands
    if (!cur_mask[idx % 12] && idx != 0) begin
      idx--;
      while (idx >= 0 && !cur_mask[idx % 12]) idx--;
      if (idx < 0) return 1'b0;
    end
    code = idx * int'(DacFull) / int'(SemisAtFull);
    if (code > int'(DacFull)) code = int'(DacFull);
    note.out_channel = it.channel;
    note.note_index  = NoteW'(idx);
    note.dac_code    = DacW'(code);
    note.spi_word    = SpiCmd | (SpiW'(code) << 2);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [SpiW-1:0] want,
                             input logic [SpiW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $realtime, name, want, got);
      n_errors++;
    end
  endtask

  // sample transfer in bursts; a typed note overrides the predicted one
  task automatic send_sample(input pcq_in_t it, input bit use_typed, input bit typed_gives,
                             input pcq_out_t typed_note);
    pcq_out_t note;
    bit       gives;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
    end
    burst_left--;
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    n_samples++;
    gives = predict_note(it, note);
    if (use_typed) begin
      gives = typed_gives;
      note  = typed_note;
    end
    if (gives) note_queue.push_back(note);
  endtask

  // wait for all notes, then for a possible search that drops its read
  task automatic wait_idle();
    push <= 1'b0;
    while (note_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // both registers, back to back on the config channel
  task automatic write_scale(input logic [CfgDataW-1:0] mask_data,
                             input logic [CfgDataW-1:0] gain_data);
    cfg_valid <= 1'b1;
    cfg_index <= CfgScaleMask;
    cfg_data  <= mask_data;
    do @(posedge clk_i); while (!cfg_ready);
    cur_mask = mask_data[MaskW-1:0];
    cfg_index <= CfgGain;
    cfg_data  <= gain_data;
    do @(posedge clk_i); while (!cfg_ready);
    cur_gain = gain_data[GainW-1:0];
    cfg_valid <= 1'b0;
    n_writes += 2;
  endtask

  // note side: check each transfer, then pick the next pop
  always @(posedge clk_i) begin : rx_side
    pcq_out_t want;
    if (rst_ni && pop && !empty) begin
      if (note_queue.size() == 0) begin
        $display("%0t: unexpected note, expected none got idx %0d code %0d", $realtime,
                 out_item.note_index, out_item.dac_code);
        n_errors++;
      end else begin
        want = note_queue.pop_front();
        check_field("out_channel", SpiW'(want.out_channel), SpiW'(out_item.out_channel));
        check_field("note_index", SpiW'(want.note_index), SpiW'(out_item.note_index));
        check_field("dac_code", SpiW'(want.dac_code), SpiW'(out_item.dac_code));
        check_field("spi_word", want.spi_word, out_item.spi_word);
        n_notes++;
      end
    end
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        RxFree:    pop <= 1'b1;
        RxPattern: pop <= StallBits[rx_cycle % 16];
        RxCoin:    pop <= 1'($urandom_range(0, 1));
        default:   pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d notes outstanding", $realtime,
               idle_cycles, note_queue.size());
      $display("** pitch_cv_scale_quantizer_unit: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    pcq_in_t             it;
    read_row_t           row;
    logic [CfgDataW-1:0] mask_data;
    logic [CfgDataW-1:0] gain_data;
    acc_sum   = '0;
    acc_count = '0;
    cur_mask  = MaskReset;
    cur_gain  = GainReset;

    // directed reads: every sample of a read at one level, channels alternate
    dir_rows[0] = '{16'(MaskReset), GainReset, 8'd0, 1'b1, 1'b1,
                    '{1'b1, 7'd0, 10'd0, SpiCmd}};
    dir_rows[1] = '{16'(MaskReset), GainReset, 8'd255, 1'b1, 1'b1,
                    '{1'b0, 7'd71, DacFull, 16'h7FFC}};
    // empty scale
    dir_rows[2] = '{16'h0000, GainReset, 8'd100, 1'b1, 1'b0, '0};
    // zero gain lands on a disabled note zero, which still stands
    dir_rows[3] = '{16'h0800, 16'd0, 8'd200, 1'b1, 1'b1,
                    '{1'b0, 7'd0, 10'd0, SpiCmd}};
    // nothing enabled at or below the index
    dir_rows[4] = '{16'h0800, 16'hFFFF, 8'd1, 1'b1, 1'b0, '0};
    dir_rows[5] = '{16'h0001, 16'hFFFF, 8'd255, 1'b0, 1'b0, '0};
    // upper data bits of the mask write are dropped
    dir_rows[6] = '{16'hFAB5, 16'd6000, 8'd77, 1'b0, 1'b0, '0};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int r = 0; r < DirReads; r++) begin
      row = dir_rows[r];
      wait_idle();
      write_scale(row.mask_data, row.gain_data);
      for (int k = 0; k < SamplesPerRead; k++) begin
        it.channel = 1'(k) ^ 1'(r);
        it.sample  = row.level;
        send_sample(it, row.typed && k == SamplesPerRead - 1, row.gives, row.note);
      end
    end

    // random phases, each under its own scale and gain
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: begin
          mask_data = 16'(MaskReset);
          gain_data = 16'hFFFF;
        end
        1: begin
          mask_data = '0;
          gain_data = 16'($urandom_range(0, 4000));
        end
        2: begin
          mask_data = 16'($urandom_range(1, 4095));
          gain_data = '0;
        end
        3: begin
          mask_data = 16'($urandom_range(0, 65535));
          gain_data = GainReset;
        end
        // every read gives a note, so the long hold fills the block
        HoldPhase: begin
          mask_data = 16'(MaskReset);
          gain_data = 16'($urandom_range(1200, 2600));
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       mask_data = 16'(MaskReset);
            1:       mask_data = 16'(1) << $urandom_range(0, 11);
            2:       mask_data = 16'($urandom_range(0, 65535));
            default: mask_data = 16'h0AB5;
          endcase
          case ($urandom_range(0, 3))
            0:       gain_data = 16'hFFFF;
            1:       gain_data = 16'($urandom_range(0, 65535));
            default: gain_data = 16'($urandom_range(1200, 2600));
          endcase
        end
      endcase
      wait_idle();
      write_scale(mask_data, gain_data);
      for (int i = 0; i < PhaseSamples; i++) begin
        it.channel = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
          0:       it.sample = '0;
          1:       it.sample = '1;
          default: it.sample = SampleW'($urandom_range(0, 255));
        endcase
        // long hold on the note side while samples keep coming
        if (p == HoldPhase && i == 20) hold_req = 1'b1;
        send_sample(it, 1'b0, 1'b0, '0);
      end
    end

    wait_idle();
    $display("run covered %0d samples, %0d notes checked, %0d register writes",
             n_samples, n_notes, n_writes);
    $display("%0d directed reads, %0d random scale/gain phases, %0d mismatches",
             DirReads, RandPhases, n_errors);
    if (n_errors == 0 && note_queue.size() == 0) begin
      $display("** pitch_cv_scale_quantizer_unit: PASSED **");
    end else begin
      $display("** pitch_cv_scale_quantizer_unit: FAILED **");
    end
    $finish;
  end

endmodule
